@@ sv/pif_pkg.sv @@
// Shared constants for the palette indexed frame store.
// Used by pif_ram's callers and by the top level; no dependencies.
`default_nettype none

package pif_pkg;

    localparam int PALETTE_SIZE = 255;
    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;

    localparam int COORD_W  = 8;
    localparam int SIZE_W   = 9;
    localparam int CHAN_W   = 8;
    localparam int COLOR_W  = 3 * CHAN_W;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;

    localparam int PIX_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int PIX_AW     = $clog2(PIX_DEPTH);
    localparam int PAL_AW     = $clog2(PALETTE_SIZE);
    localparam int ADDR_MUL_W = COORD_W + SIZE_W;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OOB  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

endpackage

`default_nettype wire

@@ sv/pif_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module pif_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/palette_indexed_framebuffer.sv @@
// A read goes through S_CHECK, S_RD_IDX and S_RD_PAL; a write goes through S_CHECK and
// S_SEARCH, the palette search, which compares one stored color per cycle with the write
// color until it finds a match, appends a new entry or reports the palette full; an out of
// bounds beat ends in S_CHECK. One beat in flight: the next beat is taken in the cycle after the result beat.
// Reset: asynchronous, active low. After reset a clearing pass writes index 0 to every
// pixel entry and black to palette entry 0, during which in_stall is high.
// Top level of the palette indexed frame store; uses pif_pkg and pif_ram.
// Holds the sequencer, the shared color comparator and the two memories.
`default_nettype none

module palette_indexed_framebuffer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            cfg_we,
    input  wire logic                            cfg_index,
    input  wire logic [pif_pkg::SIZE_W-1:0]      cfg_data,

    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            operation,
    input  wire logic [pif_pkg::COORD_W-1:0]     pos_x,
    input  wire logic [pif_pkg::COORD_W-1:0]     pos_y,
    input  wire logic [pif_pkg::CHAN_W-1:0]      in_red,
    input  wire logic [pif_pkg::CHAN_W-1:0]      in_green,
    input  wire logic [pif_pkg::CHAN_W-1:0]      in_blue,

    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [pif_pkg::STATUS_W-1:0]         status,
    output logic [pif_pkg::INDEX_W-1:0]          palette_index,
    output logic [pif_pkg::CHAN_W-1:0]           out_red,
    output logic [pif_pkg::CHAN_W-1:0]           out_green,
    output logic [pif_pkg::CHAN_W-1:0]           out_blue
);

    import pif_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_RD_IDX = 3'd3;
    localparam logic [2:0] S_RD_PAL = 3'd4;
    localparam logic [2:0] S_SEARCH = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [SIZE_W-1:0]     width_reg, height_reg;
    logic [INDEX_W-1:0]    count_reg, count_next;
    logic [PIX_AW-1:0]     clr_cnt_reg;
    logic [INDEX_W-1:0]    scan_reg, scan_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [INDEX_W-1:0]    cmp_idx_reg, cmp_idx_next;

    logic                  op_reg;
    logic [COORD_W-1:0]    x_reg, y_reg;
    logic [COLOR_W-1:0]    color_reg;
    logic [PIX_AW-1:0]     addr_reg;
    logic [INDEX_W-1:0]    rd_idx_reg;

    logic                  out_valid_reg;
    logic                  out_load;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [INDEX_W-1:0]    index_reg, index_next;
    logic [COLOR_W-1:0]    ocolor_reg, ocolor_next;

    logic [SIZE_W-1:0]     w_eff, h_eff;
    logic                  oob;
    logic [ADDR_MUL_W-1:0] addr_full;
    logic                  in_beat;
    logic                  match;

    logic                  pix_we;
    logic [PIX_AW-1:0]     pix_waddr;
    logic [INDEX_W-1:0]    pix_wdata;
    logic [INDEX_W-1:0]    pix_rdata;
    logic                  pal_we;
    logic [PAL_AW-1:0]     pal_waddr;
    logic [COLOR_W-1:0]    pal_wdata;
    logic [PAL_AW-1:0]     pal_raddr;
    logic [COLOR_W-1:0]    pal_rdata;

    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign in_beat  = in_valid && !in_stall;

    assign w_eff = (width_reg > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_reg;
    assign oob   = ({1'b0, x_reg} >= w_eff) || ({1'b0, y_reg} >= h_eff);
    assign addr_full = ADDR_MUL_W'(y_reg) * ADDR_MUL_W'(w_eff) + ADDR_MUL_W'(x_reg);

    // shared comparator: stored color from the previous read against the write color
    assign match = cmp_valid_reg && (pal_rdata == color_reg);

    pif_ram #(.WIDTH(INDEX_W), .DEPTH(PIX_DEPTH)) u_pix_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (pix_wdata),
        .raddr (addr_full[PIX_AW-1:0]),
        .rdata (pix_rdata)
    );

    pif_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_SIZE)) u_pal_ram (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (pal_wdata),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        out_load       = 1'b0;
        status_next    = STATUS_OK;
        index_next     = '0;
        ocolor_next    = '0;
        pix_we         = 1'b0;
        pix_waddr      = addr_reg;
        pix_wdata      = '0;
        pal_we         = 1'b0;
        pal_waddr      = PAL_AW'(count_reg);
        pal_wdata      = color_reg;
        pal_raddr      = PAL_AW'(scan_reg);

        unique case (state_reg)
            S_CLEAR:
            begin
                pix_we    = 1'b1;
                pix_waddr = clr_cnt_reg;
                // black into palette entry 0 on the first pass cycle
                if (clr_cnt_reg == '0)
                begin
                    pal_we    = 1'b1;
                    pal_waddr = '0;
                    pal_wdata = '0;
                end
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                scan_next      = '0;
                cmp_valid_next = 1'b0;
                if (oob)
                begin
                    out_load    = 1'b1;
                    status_next = STATUS_OOB;
                    state_next  = S_IDLE;
                end
                else if (op_reg == OP_READ)
                begin
                    state_next = S_RD_IDX;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_RD_IDX:
            begin
                pal_raddr  = PAL_AW'(pix_rdata);
                state_next = S_RD_PAL;
            end
            S_RD_PAL:
            begin
                out_load    = 1'b1;
                index_next  = rd_idx_reg;
                ocolor_next = pal_rdata;
                state_next  = S_IDLE;
            end
            S_SEARCH:
            begin
                if (match)
                begin
                    pix_we     = 1'b1;
                    pix_wdata  = cmp_idx_reg;
                    out_load   = 1'b1;
                    index_next = cmp_idx_reg;
                    state_next = S_IDLE;
                end
                else if (scan_reg < count_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg;
                    scan_next      = scan_reg + INDEX_W'(1);
                end
                else if (count_reg >= INDEX_W'(PALETTE_SIZE))
                begin
                    out_load    = 1'b1;
                    status_next = STATUS_FULL;
                    state_next  = S_IDLE;
                end
                else
                begin
                    // new color: append at the end of the palette
                    pal_we     = 1'b1;
                    pix_we     = 1'b1;
                    pix_wdata  = count_reg;
                    count_next = count_reg + INDEX_W'(1);
                    out_load   = 1'b1;
                    index_next = count_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            count_reg     <= INDEX_W'(1);
            width_reg     <= SIZE_W'(MAX_WIDTH);
            height_reg    <= SIZE_W'(MAX_HEIGHT);
            out_valid_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
            scan_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            cmp_valid_reg <= cmp_valid_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + PIX_AW'(1);
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_WIDTH)
                begin
                    width_reg <= cfg_data;
                end
                else
                begin
                    height_reg <= cfg_data;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        if (in_beat)
        begin
            op_reg    <= operation;
            x_reg     <= pos_x;
            y_reg     <= pos_y;
            color_reg <= {in_red, in_green, in_blue};
        end
        if (state_reg == S_CHECK)
        begin
            addr_reg <= addr_full[PIX_AW-1:0];
        end
        if (state_reg == S_RD_IDX)
        begin
            rd_idx_reg <= pix_rdata;
        end
        if (out_load)
        begin
            status_reg <= status_next;
            index_reg  <= index_next;
            ocolor_reg <= ocolor_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign palette_index = index_reg;
    assign out_red       = ocolor_reg[COLOR_W-1 -: CHAN_W];
    assign out_green     = ocolor_reg[CHAN_W +: CHAN_W];
    assign out_blue      = ocolor_reg[CHAN_W-1:0];

`ifndef SYNTHESIS
    a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH && pal_we) |=> (count_reg == $past(count_reg) + INDEX_W'(1)))
        else $error("palette append did not advance the entry count");

    a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == STATUS_OOB) |->
        (index_reg == '0 && ocolor_reg == '0))
        else $error("out of bounds result carries nonzero payload");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> in_stall)
        else $error("input beat possible during clearing pass");

    a_pix_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_we && state_reg != S_CLEAR) |-> (out_load && status_next == STATUS_OK))
        else $error("pixel store written without a successful write result");
`endif

endmodule

`default_nettype wire
